// ===== src/tcpoor_pkg.sv =====
// Shared types, codes and the sequence-compare helper for the range tracker.
package tcpoor_pkg;

  localparam logic [2:0] OUT_ADVANCED  = 3'd0;
  localparam logic [2:0] OUT_DUPLICATE = 3'd1;
  localparam logic [2:0] OUT_HELD      = 3'd2;
  localparam logic [2:0] OUT_EMPTY     = 3'd3;
  localparam logic [2:0] OUT_DROPPED   = 3'd4;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SACK   = 1'b1;

  localparam logic [1:0] REG_INIT_SEQ  = 2'd0;
  localparam logic [1:0] REG_SACK_LIM  = 2'd1;

  localparam logic [3:0] SACK_CAP = 4'd8;

  typedef struct packed {
    logic accept;
    logic setup;
    logic proc;
    logic tail;
    logic commit;
    logic stat;
    logic srd;
    logic semit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic any_held;
    logic adv;
    logic last_entry;
    logic out_free;
    logic sack_none;
    logic sack_last;
  } sts_t;

  function automatic logic sq_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ===== src/tcpoor_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
module tcpoor_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/tcpoor_ctrl.sv =====
// Sequencing state machine: setup, table walk, commit, result emission.
module tcpoor_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcpoor_pkg::sts_t   sts_i,
  output tcpoor_pkg::cmd_t   cmd_o
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_RD     = 9'b000000100,
    S_PROC   = 9'b000001000,
    S_TAIL   = 9'b000010000,
    S_COMMIT = 9'b000100000,
    S_STAT   = 9'b001000000,
    S_SRD    = 9'b010000000,
    S_SEMIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.setup = 1'b1;
        if (sts_i.skip) state_d = S_STAT;
        else if (sts_i.any_held) state_d = S_RD;
        else state_d = S_TAIL;
      end
      S_RD: state_d = S_PROC;
      S_PROC: begin
        cmd_o.proc = 1'b1;
        if (sts_i.adv) state_d = sts_i.last_entry ? S_TAIL : S_RD;
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_STAT;
      end
      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.stat = 1'b1;
          state_d    = sts_i.sack_none ? S_IDLE : S_SRD;
        end
      end
      S_SRD: begin
        cmd_o.srd = 1'b1;
        state_d   = S_SEMIT;
      end
      S_SEMIT: begin
        cmd_o.srd = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.semit = 1'b1;
          state_d     = sts_i.sack_last ? S_IDLE : S_SRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== src/tcpoor_dp.sv =====
// Datapath: frontier, counters, ping-pong range table, merge/drain and output register.
module tcpoor_dp #(
  parameter int MaxRanges = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcpoor_pkg::cmd_t  cmd_i,
  output tcpoor_pkg::sts_t  sts_o,
  input  logic [31:0]       segment_sequence_i,
  input  logic [15:0]       segment_length_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              item_kind_o,
  output logic [2:0]        outcome_o,
  output logic [31:0]       frontier_o,
  output logic [3:0]        held_count_o,
  output logic [31:0]       duplicate_total_o,
  output logic [31:0]       out_of_order_total_o,
  output logic [31:0]       block_start_o,
  output logic [31:0]       block_end_o,
  output logic              last_o
);
  localparam int IW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int CW = $clog2(MaxRanges + 1);
  localparam int NW = (CW > 4) ? CW : 4;
  localparam int AW = IW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MaxRanges);

  logic [31:0]   seq_q, cs_q, cs_d, ce_q, ce_d, nf_q, nf_d, nexp_q, nexp_d;
  logic [15:0]   len_q;
  logic [31:0]   dup_q, dup_d, ooo_q, ooo_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, wcnt_q, wcnt_d, k_q, k_d, nblk, sidx;
  logic          bank_q, bank_d, placed_q, placed_d, drain_q, drain_d, full_q, full_d;
  logic [2:0]    outc_q, outc_d;
  logic [3:0]    lim_q, lim_d, lim_sat;
  logic [31:0]   rs, re, es, ee, ce_new, cs_trim;
  logic [63:0]   rdata;
  logic          emit, we, adv, below, above, free;
  logic [AW-1:0] raddr, waddr;

  // output register
  logic        ov_q, ov_d, kind_q, kind_d, last_q, last_d;
  logic [2:0]  oout_q, oout_d;
  logic [31:0] ofr_q, ofr_d, odup_q, odup_d, oooo_q, oooo_d, obs_q, obs_d, obe_q, obe_d;
  logic [3:0]  ohc_q, ohc_d;

  assign rs = rdata[63:32];
  assign re = rdata[31:0];
  assign sidx  = cnt_q - k_q;
  assign raddr = cmd_i.srd ? {bank_q, sidx[IW-1:0]} : {bank_q, i_q[IW-1:0]};
  assign waddr = {~bank_q, wcnt_q[IW-1:0]};

  tcpoor_ram #(.Width(64), .Depth(2 ** AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({es, ee}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ce_new  = seq_q + {16'd0, len_q};
  assign cs_trim = tcpoor_pkg::sq_lt(seq_q, nexp_q) ? nexp_q : seq_q;
  assign below   = tcpoor_pkg::sq_lt(re, cs_q);
  assign above   = tcpoor_pkg::sq_lt(ce_q, rs);
  assign lim_sat = (lim_q > tcpoor_pkg::SACK_CAP) ? tcpoor_pkg::SACK_CAP : lim_q;
  assign nblk    = (NW'(cnt_q) < NW'(lim_sat)) ? cnt_q : CW'(lim_sat);
  assign free    = !ov_q || !out_stall_i;

  always_comb begin
    emit = 1'b0;
    es   = cs_q;
    ee   = ce_q;
    adv  = 1'b0;
    cs_d = cs_q;
    ce_d = ce_q;
    placed_d = placed_q;
    if (cmd_i.proc) begin
      adv = 1'b1;
      if (below) begin
        emit = 1'b1; es = rs; ee = re;
      end else if (above) begin
        emit = 1'b1;
        if (!placed_q) begin
          placed_d = 1'b1;
          adv      = 1'b0;
        end else begin
          es = rs; ee = re;
        end
      end else begin
        if (tcpoor_pkg::sq_lt(rs, cs_q)) cs_d = rs;
        if (tcpoor_pkg::sq_lt(ce_q, re)) ce_d = re;
      end
    end
    if (cmd_i.tail && !placed_q) emit = 1'b1;
    if (cmd_i.setup) begin
      cs_d     = cs_trim;
      ce_d     = ce_new;
      placed_d = 1'b0;
    end
  end

  always_comb begin
    nf_d    = nf_q;
    drain_d = drain_q;
    full_d  = full_q;
    wcnt_d  = wcnt_q;
    we      = 1'b0;
    i_d     = adv ? i_q + CW'(1) : i_q;
    if (emit) begin
      if (drain_q && !tcpoor_pkg::sq_lt(nf_q, es)) begin
        if (tcpoor_pkg::sq_lt(nf_q, ee)) nf_d = ee;
      end else begin
        drain_d = 1'b0;
        if (wcnt_q == MaxCnt) begin
          full_d = 1'b1;
        end else begin
          we     = 1'b1;
          wcnt_d = wcnt_q + CW'(1);
        end
      end
    end
    if (cmd_i.setup) begin
      nf_d = nexp_q; drain_d = 1'b1; full_d = 1'b0; wcnt_d = '0; i_d = '0;
    end
  end

  always_comb begin
    nexp_d = nexp_q;
    cnt_d  = cnt_q;
    bank_d = bank_q;
    dup_d  = dup_q;
    ooo_d  = ooo_q;
    outc_d = outc_q;
    lim_d  = lim_q;
    k_d    = k_q;
    if (cmd_i.setup) begin
      if (len_q == 16'd0) begin
        outc_d = tcpoor_pkg::OUT_EMPTY;
      end else if (!tcpoor_pkg::sq_lt(nexp_q, ce_new)) begin
        outc_d = tcpoor_pkg::OUT_DUPLICATE;
        dup_d  = dup_q + 32'd1;
      end
    end
    if (cmd_i.commit) begin
      if (full_q) begin
        outc_d = tcpoor_pkg::OUT_DROPPED;
        ooo_d  = ooo_q + 32'd1;
      end else begin
        cnt_d  = wcnt_q;
        bank_d = ~bank_q;
        if (nf_q != nexp_q) begin
          nexp_d = nf_q;
          outc_d = tcpoor_pkg::OUT_ADVANCED;
        end else begin
          outc_d = tcpoor_pkg::OUT_HELD;
          ooo_d  = ooo_q + 32'd1;
        end
      end
    end
    if (cmd_i.stat) k_d = CW'(1);
    if (cmd_i.semit) k_d = k_q + CW'(1);
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcpoor_pkg::REG_INIT_SEQ: begin
          nexp_d = cfg_wdata_i;
          cnt_d  = '0;
        end
        tcpoor_pkg::REG_SACK_LIM: lim_d = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ov_d = ov_q; kind_d = kind_q; last_d = last_q; oout_d = oout_q; ofr_d = ofr_q;
    odup_d = odup_q; oooo_d = oooo_q; obs_d = obs_q; obe_d = obe_q; ohc_d = ohc_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (cmd_i.stat || cmd_i.semit) begin
      ov_d   = 1'b1;
      oout_d = outc_q;
      ofr_d  = nexp_q;
      ohc_d  = 4'(cnt_q);
      odup_d = dup_q;
      oooo_d = ooo_q;
      if (cmd_i.stat) begin
        kind_d = tcpoor_pkg::KIND_STATUS;
        obs_d  = '0;
        obe_d  = '0;
        last_d = (nblk == '0);
      end else begin
        kind_d = tcpoor_pkg::KIND_SACK;
        obs_d  = rs;
        obe_d  = re;
        last_d = (k_q == nblk);
      end
    end
  end

  assign sts_o.skip       = (len_q == 16'd0) || !tcpoor_pkg::sq_lt(nexp_q, ce_new);
  assign sts_o.any_held   = (cnt_q != '0);
  assign sts_o.adv        = adv;
  assign sts_o.last_entry = (i_q + CW'(1) == cnt_q);
  assign sts_o.out_free   = free;
  assign sts_o.sack_none  = (nblk == '0);
  assign sts_o.sack_last  = (k_q == nblk);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      seq_q <= segment_sequence_i;
      len_q <= segment_length_i;
    end
    cs_q <= cs_d; ce_q <= ce_d; nf_q <= nf_d;
    oout_q <= oout_d; ofr_q <= ofr_d; odup_q <= odup_d; oooo_q <= oooo_d;
    obs_q <= obs_d; obe_q <= obe_d; ohc_q <= ohc_d; kind_q <= kind_d; last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nexp_q <= '0; cnt_q <= '0; bank_q <= 1'b0; dup_q <= '0; ooo_q <= '0;
      outc_q <= tcpoor_pkg::OUT_ADVANCED; lim_q <= 4'd4; k_q <= '0; i_q <= '0;
      wcnt_q <= '0; placed_q <= 1'b0; drain_q <= 1'b0; full_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      nexp_q <= nexp_d; cnt_q <= cnt_d; bank_q <= bank_d; dup_q <= dup_d; ooo_q <= ooo_d;
      outc_q <= outc_d; lim_q <= lim_d; k_q <= k_d; i_q <= i_d;
      wcnt_q <= wcnt_d; placed_q <= placed_d; drain_q <= drain_d; full_q <= full_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o          = ov_q;
  assign item_kind_o          = kind_q;
  assign outcome_o            = oout_q;
  assign frontier_o           = ofr_q;
  assign held_count_o         = ohc_q;
  assign duplicate_total_o    = odup_q;
  assign out_of_order_total_o = oooo_q;
  assign block_start_o        = obs_q;
  assign block_end_o          = obe_q;
  assign last_o               = last_q;
endmodule

// ===== src/tcp_out_of_order_range_tracker_top.sv =====
// Top level of the TCP out-of-order range tracker with SACK reporting.
//  channel | direction | handshake              | payload
//  in      | in        | in_valid_i/in_stall_o  | segment_sequence_i, segment_length_i
//  out     | out       | out_valid_o/out_stall_i| item_kind_o .. last_o
//  cfg     | in        | cfg_we_i               | cfg_index_i, cfg_wdata_i
// One segment at a time: the item is taken and checked, then each held range is read and
// merged in the walk (one more step when the new range is slotted in); tail and commit
// follow, then a status item and a read and emit per SACK block via the one read port.
// Empty and duplicate segments skip the walk and go straight to status.
// Reset empties the table and counters; no clearing pass is needed.
// Output stalls hold the block in its emit states; one result register decouples.
module tcp_out_of_order_range_tracker_top #(
  parameter int MaxRanges = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] segment_sequence_i,
  input  logic [15:0] segment_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [2:0]  outcome_o,
  output logic [31:0] frontier_o,
  output logic [3:0]  held_count_o,
  output logic [31:0] duplicate_total_o,
  output logic [31:0] out_of_order_total_o,
  output logic [31:0] block_start_o,
  output logic [31:0] block_end_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  tcpoor_pkg::cmd_t cmd;
  tcpoor_pkg::sts_t sts;

  tcpoor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcpoor_dp #(.MaxRanges(MaxRanges)) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .segment_sequence_i   (segment_sequence_i),
    .segment_length_i     (segment_length_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .item_kind_o          (item_kind_o),
    .outcome_o            (outcome_o),
    .frontier_o           (frontier_o),
    .held_count_o         (held_count_o),
    .duplicate_total_o    (duplicate_total_o),
    .out_of_order_total_o (out_of_order_total_o),
    .block_start_o        (block_start_o),
    .block_end_o          (block_end_o),
    .last_o               (last_o)
  );

`ifndef ASSERT_OFF
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_kind_o == tcpoor_pkg::KIND_STATUS)
      |-> (block_start_o == 32'd0 && block_end_o == 32'd0))
    else $error("status item carries a block");
  a_sack_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_kind_o == tcpoor_pkg::KIND_SACK) |-> (held_count_o != 4'd0))
    else $error("sack item with empty table");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted item did not start processing");
`endif
endmodule
